// ----- rtl/rotated_grating_pixel_generator_top_macros.svh -----
// Assertion macros shared by the grating generator checker.
`ifndef ROTATED_GRATING_PIXEL_GENERATOR_TOP_MACROS_SVH
`define ROTATED_GRATING_PIXEL_GENERATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RGPG_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RGPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rgpg_pkg.sv -----
// Types, constants and trigonometric table builders for the grating generator.
`timescale 1ns / 1ps
`default_nettype none
package rgpg_pkg;

  localparam int TrigSize  = 1024;
  localparam int TrigIdxW  = $clog2(TrigSize);
  localparam int TrigW     = 16;
  localparam int HalfTurn  = 46080;
  localparam int FullTurn  = 92160;
  localparam int AngRound  = HalfTurn / TrigSize;
  localparam int AngStep   = FullTurn / TrigSize;
  localparam int AngShift  = 23;
  localparam int AngRecip  = ((1 << AngShift) + AngStep - 1) / AngStep;
  localparam int AngW      = 18;
  localparam int CtrW      = 13;
  localparam int UW        = 14;
  localparam int AccW      = 31;
  localparam int MagW      = AccW - 14;
  localparam int DivW      = 20;
  localparam int DivisorW  = 9;
  localparam int RemW      = 9;
  localparam int MixW      = 27;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 8;

  localparam logic [CfgIdxW-1:0] CfgGrayMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPeriod     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWidth      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgForeground = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBackground = 3'd4;

  localparam longint unsigned PiQ30     = 64'd3373259426;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned TwoPiQ30  = 64'd6746518852;
  localparam longint          OneQ30    = 64'sd1073741824;

  typedef logic [TrigSize-1:0][TrigW-1:0] lut_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADV_RED, S_ADV_IDX, S_ADV_TRIG,
    S_Q_MUL1, S_Q_MUL2, S_Q_MDIV, S_Q_MWAIT, S_Q_MOD,
    S_Q_KDIV, S_Q_KWAIT, S_Q_LUT, S_Q_MIX, S_Q_OUT
  } state_e;

  typedef enum logic [1:0] {
    DIV_MOD, DIV_IDX
  } div_sel_e;

  typedef struct packed {
    logic     load_adv;
    logic     load_qry;
    logic     red_step;
    logic     ang_idx;
    logic     div_start;
    div_sel_e div_sel;
    logic     trig_load;
    logic     mul1;
    logic     mul2;
    logic     mod_calc;
    logic     lut_load;
    logic     mix;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;
    logic div_done;
    logic gray;
    logic out_full;
  } dp_sts_t;

  // Truncated Taylor sine in Q30, rounded to Q1.14.
  // Term n is divided by (2n)(2n+1): 6, 20, 42, 72, 110, 156 and 210.
  function automatic logic [TrigW-1:0] sine_q14(longint unsigned x_in);
    longint unsigned x, x2, term;
    longint sum;
    logic neg;
    x = x_in;
    neg = 1'b0;
    if (x >= PiQ30) begin
      x = x - PiQ30;
      neg = 1'b1;
    end
    if (x > HalfPiQ30) x = PiQ30 - x;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - longint'(term);
    if (sum < 0) sum = 0;
    if (sum > OneQ30) sum = OneQ30;
    sum = (sum + 32768) >>> 16;
    return neg ? TrigW'(-sum) : TrigW'(sum);
  endfunction

  function automatic logic [TrigW-1:0] trig_q14(int k, logic want_cos);
    longint unsigned x, xc;
    x = longint'(k % TrigSize) * TwoPiQ30 / TrigSize;
    xc = x + HalfPiQ30;
    if (xc >= TwoPiQ30) xc = xc - TwoPiQ30;
    return want_cos ? sine_q14(xc) : sine_q14(x);
  endfunction

  function automatic lut_t build_lut(logic want_cos);
    lut_t t;
    for (int i = 0; i < TrigSize; i++) t[i] = trig_q14(i, want_cos);
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rgpg_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rgpg_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rgpg_pkg::DivW-1:0]     dividend_i,
  input  wire logic [rgpg_pkg::DivisorW-1:0] divisor_i,
  output logic                               done_o,
  output logic [rgpg_pkg::DivW-1:0]          quot_o,
  output logic [rgpg_pkg::RemW-1:0]          rem_o
);
  localparam int DW   = rgpg_pkg::DivW;
  localparam int RW   = rgpg_pkg::RemW;
  localparam int CntW = $clog2(DW + 1);

  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          busy_q, busy_d, done_q, done_d;
  logic [RW-1:0]                 rem_q, rem_d;
  logic [DW-1:0]                 quo_q, quo_d;
  logic [rgpg_pkg::DivisorW-1:0] dsr_q, dsr_d;
  logic [RW:0]                   trial, diff;
  logic                          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      cnt_d  = CntW'(DW);
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[RW-1:0] : trial[RW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// ----- rtl/rgpg_ctrl.sv -----
// Sequencer that steps the datapath through an advance or a pixel query.
`timescale 1ns / 1ps
`default_nettype none
module rgpg_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  input  wire logic              kind_i,
  output logic                   s_ready_o,
  input  wire rgpg_pkg::dp_sts_t sts_i,
  output rgpg_pkg::dp_cmd_t      cmd_o
);
  rgpg_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rgpg_pkg::S_IDLE:
        if (s_valid_i) state_d = kind_i ? rgpg_pkg::S_Q_MUL1 : rgpg_pkg::S_ADV_RED;
      rgpg_pkg::S_ADV_RED:  if (sts_i.red_done) state_d = rgpg_pkg::S_ADV_IDX;
      rgpg_pkg::S_ADV_IDX:  state_d = rgpg_pkg::S_ADV_TRIG;
      rgpg_pkg::S_ADV_TRIG: state_d = rgpg_pkg::S_IDLE;
      rgpg_pkg::S_Q_MUL1:   state_d = rgpg_pkg::S_Q_MUL2;
      rgpg_pkg::S_Q_MUL2:   state_d = rgpg_pkg::S_Q_MDIV;
      rgpg_pkg::S_Q_MDIV:   state_d = rgpg_pkg::S_Q_MWAIT;
      rgpg_pkg::S_Q_MWAIT:  if (sts_i.div_done) state_d = rgpg_pkg::S_Q_MOD;
      rgpg_pkg::S_Q_MOD:
        state_d = sts_i.gray ? rgpg_pkg::S_Q_KDIV : rgpg_pkg::S_Q_OUT;
      rgpg_pkg::S_Q_KDIV:   state_d = rgpg_pkg::S_Q_KWAIT;
      rgpg_pkg::S_Q_KWAIT:  if (sts_i.div_done) state_d = rgpg_pkg::S_Q_LUT;
      rgpg_pkg::S_Q_LUT:    state_d = rgpg_pkg::S_Q_MIX;
      rgpg_pkg::S_Q_MIX:    state_d = rgpg_pkg::S_Q_OUT;
      rgpg_pkg::S_Q_OUT:    if (!sts_i.out_full) state_d = rgpg_pkg::S_IDLE;
      default:              state_d = rgpg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = rgpg_pkg::DIV_MOD;
    s_ready_o = 1'b0;
    unique case (state_q)
      rgpg_pkg::S_IDLE: begin
        s_ready_o = 1'b1;
        cmd_o.load_adv = s_valid_i && !kind_i;
        cmd_o.load_qry = s_valid_i && kind_i;
      end
      rgpg_pkg::S_ADV_RED:  cmd_o.red_step = 1'b1;
      rgpg_pkg::S_ADV_IDX:  cmd_o.ang_idx = 1'b1;
      rgpg_pkg::S_ADV_TRIG: cmd_o.trig_load = 1'b1;
      rgpg_pkg::S_Q_MUL1:   cmd_o.mul1 = 1'b1;
      rgpg_pkg::S_Q_MUL2:   cmd_o.mul2 = 1'b1;
      rgpg_pkg::S_Q_MDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = rgpg_pkg::DIV_MOD;
      end
      rgpg_pkg::S_Q_MOD:    cmd_o.mod_calc = 1'b1;
      rgpg_pkg::S_Q_KDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = rgpg_pkg::DIV_IDX;
      end
      rgpg_pkg::S_Q_LUT:    cmd_o.lut_load = 1'b1;
      rgpg_pkg::S_Q_MIX:    cmd_o.mix = 1'b1;
      rgpg_pkg::S_Q_OUT:    cmd_o.out_load = !sts_i.out_full;
      default:              cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rgpg_pkg::S_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// ----- rtl/rgpg_dp.sv -----
// Datapath: motion state, projection, shared divider, trig tables and output register.
`timescale 1ns / 1ps
`default_nettype none
module rgpg_dp #(
  parameter int FRAME_WIDTH  = 32,
  parameter int FRAME_HEIGHT = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rgpg_pkg::dp_cmd_t              cmd_i,
  output rgpg_pkg::dp_sts_t                   sts_o,
  input  wire logic signed [16:0]             delta_angle_i,
  input  wire logic signed [9:0]              delta_x_i,
  input  wire logic signed [9:0]              delta_y_i,
  input  wire logic [4:0]                     pixel_x_i,
  input  wire logic [4:0]                     pixel_y_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [rgpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rgpg_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [15:0]                         out_level_o
);
  localparam int AW = rgpg_pkg::AngW;
  localparam int CW = rgpg_pkg::CtrW;
  localparam int UW = rgpg_pkg::UW;
  localparam int DW = rgpg_pkg::DivW;
  localparam int KW = rgpg_pkg::TrigIdxW;
  localparam logic signed [AW-1:0] HalfTurnS = AW'(rgpg_pkg::HalfTurn);
  localparam logic signed [AW-1:0] FullTurnS = AW'(rgpg_pkg::FullTurn);
  localparam logic signed [CW-1:0] ModXS = CW'(10 * FRAME_WIDTH);
  localparam logic signed [CW-1:0] ModYS = CW'(10 * FRAME_HEIGHT);
  localparam logic [UW-1:0] HalfW = UW'(FRAME_WIDTH / 2);
  localparam logic [UW-1:0] HalfH = UW'(FRAME_HEIGHT / 2);
  localparam rgpg_pkg::lut_t CosLut = rgpg_pkg::build_lut(1'b1);
  localparam rgpg_pkg::lut_t SinLut = rgpg_pkg::build_lut(1'b0);

  // Configuration registers.
  logic       gray_q;
  logic [7:0] period_q, width_q, fg_q, bg_q;

  // Motion state.
  logic signed [AW-1:0] angle_q, angle_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [15:0]   cos_q, sin_q;
  logic [KW-1:0]        ang_k_q;

  // Query working registers.
  logic [4:0]                       px_q, py_q;
  logic signed [rgpg_pkg::AccW-1:0] acc_q;
  logic [7:0]                       r_q;
  logic signed [15:0]               c_q;
  logic signed [rgpg_pkg::MixW-1:0] mix_q;
  logic                             out_valid_q;
  logic [15:0]                      out_level_q;

  logic                 red_done;
  logic signed [AW-1:0] apos;
  logic [16:0]          ang_n;
  logic [33:0]          ang_prod;
  logic signed [UW-1:0] u_w, v_w, mul_a;
  logic signed [15:0]   mul_b;
  logic signed [29:0]   prod;
  logic [rgpg_pkg::AccW-1:0] abs_acc;
  logic                 neg;
  logic [7:0]           per_eff, rem8, r_d;
  logic [DW-1:0]        div_dividend;
  logic [rgpg_pkg::DivisorW-1:0] div_divisor;
  logic                 div_done;
  logic [DW-1:0]        div_quot;
  logic [rgpg_pkg::RemW-1:0] div_rem;
  logic [KW-1:0]        k_idx;
  logic signed [17:0]   weight;
  logic signed [8:0]    span;
  logic signed [27:0]   total;
  logic [15:0]          level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_q   <= 1'b1;
      period_q <= 8'd8;
      width_q  <= 8'd3;
      fg_q     <= 8'd255;
      bg_q     <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rgpg_pkg::CfgGrayMode:   gray_q   <= cfg_data_i[0];
        rgpg_pkg::CfgPeriod:     period_q <= cfg_data_i;
        rgpg_pkg::CfgWidth:      width_q  <= cfg_data_i;
        rgpg_pkg::CfgForeground: fg_q     <= cfg_data_i;
        rgpg_pkg::CfgBackground: bg_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Each reduction step moves a value one modulus closer to zero.
  always_comb begin
    angle_d = angle_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    if (cmd_i.load_adv) begin
      angle_d = angle_q + {delta_angle_i[16], delta_angle_i};
      cx_d    = cx_q + {{(CW-10){delta_x_i[9]}}, delta_x_i};
      cy_d    = cy_q + {{(CW-10){delta_y_i[9]}}, delta_y_i};
    end else if (cmd_i.red_step) begin
      if (angle_q >= HalfTurnS) angle_d = angle_q - HalfTurnS;
      else if (angle_q <= -HalfTurnS) angle_d = angle_q + HalfTurnS;
      if (cx_q >= ModXS) cx_d = cx_q - ModXS;
      else if (cx_q <= -ModXS) cx_d = cx_q + ModXS;
      if (cy_q >= ModYS) cy_d = cy_q - ModYS;
      else if (cy_q <= -ModYS) cy_d = cy_q + ModYS;
    end
  end

  assign red_done = (angle_q < HalfTurnS) && (angle_q > -HalfTurnS) &&
                    (cx_q < ModXS) && (cx_q > -ModXS) &&
                    (cy_q < ModYS) && (cy_q > -ModYS);

  assign apos = (angle_q < 0) ? angle_q + FullTurnS : angle_q;

  // Nearest table step of the folded angle: the division by the step size is a
  // reciprocal multiplication, exact for every folded angle.
  assign ang_n    = apos[AW-2:0] + 17'(rgpg_pkg::AngRound);
  assign ang_prod = ang_n * 17'(rgpg_pkg::AngRecip);

  assign u_w   = $signed({{(UW-5){1'b0}}, px_q}) - $signed(HalfW) -
                 $signed({{(UW-CW){cx_q[CW-1]}}, cx_q});
  assign v_w   = $signed({{(UW-5){1'b0}}, py_q}) - $signed(HalfH) -
                 $signed({{(UW-CW){cy_q[CW-1]}}, cy_q});
  assign mul_a = cmd_i.mul2 ? v_w : u_w;
  assign mul_b = cmd_i.mul2 ? sin_q : cos_q;
  assign prod  = mul_a * mul_b;

  assign neg     = acc_q[rgpg_pkg::AccW-1];
  assign abs_acc = neg ? -acc_q : acc_q;
  assign per_eff = (period_q == 8'd0) ? 8'd1 : period_q;
  assign rem8    = div_rem[7:0];
  assign r_d     = (neg && rem8 != 8'd0) ? per_eff - rem8 : rem8;

  always_comb begin
    unique case (cmd_i.div_sel)
      rgpg_pkg::DIV_MOD: begin
        div_dividend = DW'(abs_acc[rgpg_pkg::AccW-1:14]);
        div_divisor  = {1'b0, per_eff};
      end
      rgpg_pkg::DIV_IDX: begin
        div_dividend = DW'({r_q, {(KW + 1){1'b0}}}) + DW'(per_eff);
        div_divisor  = {per_eff, 1'b0};
      end
      default: begin
        div_dividend = '0;
        div_divisor  = {1'b0, per_eff};
      end
    endcase
  end

  rgpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign k_idx  = div_quot[KW-1:0];
  assign weight = 18'sd16384 + {{2{c_q[15]}}, c_q};
  assign span   = $signed({1'b0, fg_q}) - $signed({1'b0, bg_q});
  assign total  = $signed({5'b0, bg_q, 15'b0}) + 28'(mix_q) + 28'sd64;

  always_comb begin
    if (gray_q) level_d = (total < 0) ? 16'd0 : total[22:7];
    else level_d = {(r_q < width_q) ? fg_q : bg_q, 8'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q     <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      cos_q       <= 16'sd16384;
      sin_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      angle_q <= angle_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      if (cmd_i.trig_load) begin
        cos_q <= CosLut[ang_k_q];
        sin_q <= SinLut[ang_k_q];
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ang_idx) ang_k_q <= ang_prod[rgpg_pkg::AngShift +: KW];
    if (cmd_i.load_qry) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    if (cmd_i.mul1) acc_q <= rgpg_pkg::AccW'(prod);
    else if (cmd_i.mul2) acc_q <= acc_q + rgpg_pkg::AccW'(prod);
    if (cmd_i.mod_calc) r_q <= r_d;
    if (cmd_i.lut_load) c_q <= CosLut[k_idx];
    if (cmd_i.mix) mix_q <= weight * span;
    if (cmd_i.out_load) out_level_q <= level_d;
  end

  assign sts_o.red_done = red_done;
  assign sts_o.div_done = div_done;
  assign sts_o.gray     = gray_q;
  assign sts_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_level_o    = out_level_q;
endmodule
`default_nettype wire

// ----- rtl/rotated_grating_pixel_generator_top.sv -----
// Advance: no divider pass; reduction repeats while the angle or a centre needs wrapping.
// Binary pixel query: one 20-step divider pass; gray pixel query: two.
// One beat is worked on at a time; the next is taken while a result still waits in the
// output register. Reset is asynchronous and active low; it restores the angle, centre,
// cosine and sine and the configuration registers to their defaults. There is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module rotated_grating_pixel_generator_top #(
  parameter int FRAME_WIDTH  = 32,
  parameter int FRAME_HEIGHT = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // delta_angle[16:0], delta_x[26:17], delta_y[36:27], pixel_x[41:37], pixel_y[46:42]
  input  wire logic [47:0] s_axis_tdata,
  // kind[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pixel_level[15:0]
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [rgpg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rgpg_pkg::CfgDataW-1:0] cfg_data_i
);
  rgpg_pkg::dp_cmd_t cmd;
  rgpg_pkg::dp_sts_t sts;

  rgpg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .kind_i    (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rgpg_dp #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .delta_angle_i (s_axis_tdata[16:0]),
    .delta_x_i     (s_axis_tdata[26:17]),
    .delta_y_i     (s_axis_tdata[36:27]),
    .pixel_x_i     (s_axis_tdata[41:37]),
    .pixel_y_i     (s_axis_tdata[46:42]),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_level_o   (m_axis_tdata)
  );
endmodule
`default_nettype wire

// ----- rtl/rgpg_checker.sv -----
// Port-level checks on the grating generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "rotated_grating_pixel_generator_top_macros.svh"
module rgpg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);
  `RGPG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output beat changed")
  `RGPG_ASSERT_NEXT(a_one_beat, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a beat is in work")
  `RGPG_ASSERT_NEXT(a_adv_silent, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !$rose(m_axis_tvalid), "advance beat produced a result")
endmodule

bind rotated_grating_pixel_generator_top rgpg_checker u_rgpg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- sim/tb_rotated_grating_pixel_generator_top.sv -----
// Self-checking testbench for the rotated grating pixel generator.
`timescale 1ns / 1ps

class grating_scoreboard;
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;

  bit        gray_mode;
  bit [7:0]  period, stripe_w, fg_level, bg_level;
  int        angle, centre_x, centre_y, cos_q14, sin_q14;
  bit [15:0] level_q[$];
  int        fails;

  function void reset_state();
    gray_mode = 1'b1;
    period    = 8'd8;
    stripe_w  = 8'd3;
    fg_level  = 8'd255;
    bg_level  = 8'd0;
    angle     = 0;
    centre_x  = 0;
    centre_y  = 0;
    cos_q14   = 16384;
    sin_q14   = 0;
    level_q.delete();
    fails     = 0;
  endfunction

  function void set_reg(bit [2:0] idx, bit [7:0] val);
    case (idx)
      rgpg_pkg::CfgGrayMode:   gray_mode = val[0];
      rgpg_pkg::CfgPeriod:     period    = val;
      rgpg_pkg::CfgWidth:      stripe_w  = val;
      rgpg_pkg::CfgForeground: fg_level  = val;
      rgpg_pkg::CfgBackground: bg_level  = val;
      default: ;
    endcase
  endfunction

  // Taylor series sine through the fifteenth power, each term truncated in Q30.
  function int taylor_sine(longint unsigned x_in);
    longint unsigned x, x2, term;
    longint sum;
    bit neg;
    x = x_in;
    neg = 1'b0;
    if (x >= PI_Q30) begin
      x = x - PI_Q30;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q30) x = PI_Q30 - x;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    sum = (sum + 32768) >>> 16;
    return neg ? -int'(sum) : int'(sum);
  endfunction

  function void table_trig(longint unsigned idx, output int c, output int s);
    longint unsigned x, xc;
    x = (idx % 1024) * TWO_PI_Q30 / 1024;
    xc = x + HALF_PI_Q30;
    if (xc >= TWO_PI_Q30) xc = xc - TWO_PI_Q30;
    s = taylor_sine(x);
    c = taylor_sine(xc);
  endfunction

  function void note_beat(bit is_query, bit signed [16:0] d_ang, bit signed [9:0] d_x,
                          bit signed [9:0] d_y, bit [4:0] px, bit [4:0] py);
    longint a, u, v, num, p, per, r, total;
    longint unsigned apos, idx;
    int c, s;
    if (!is_query) begin
      a = (longint'(angle) + d_ang) % 46080;
      angle = int'(a);
      centre_x = (centre_x + int'(d_x)) % 320;
      centre_y = (centre_y + int'(d_y)) % 320;
      apos = (a < 0) ? longint'(a + 92160) : longint'(a);
      idx = (apos * 1024 + 46080) / 92160;
      table_trig(idx, cos_q14, sin_q14);
    end else begin
      u = longint'(px) - 16 - centre_x;
      v = longint'(py) - 16 - centre_y;
      num = u * cos_q14 + v * sin_q14;
      p = num / 16384;
      per = (period == 0) ? 1 : longint'(period);
      r = p % per;
      if (r < 0) r = r + per;
      if (gray_mode) begin
        idx = (r * 2048 + per) / (2 * per);
        table_trig(idx, c, s);
        total = longint'(bg_level) * 32768
              + (16384 + longint'(c)) * (longint'(fg_level) - longint'(bg_level)) + 64;
        if (total < 0) total = 0;
        level_q.push_back(16'(total >>> 7));
      end else begin
        level_q.push_back((r < longint'(stripe_w)) ? {fg_level, 8'h00} : {bg_level, 8'h00});
      end
    end
  endfunction

  function void check_level(bit [15:0] got);
    bit [15:0] want;
    if (level_q.size() == 0) begin
      $error("pixel_level: no result expected, got %0d", got);
      fails++;
    end else begin
      want = level_q.pop_front();
      if (want !== got) begin
        $error("pixel_level: expected %0d, actual %0d", want, got);
        fails++;
      end
    end
  endfunction
endclass

module tb_rotated_grating_pixel_generator_top;
  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [rgpg_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [rgpg_pkg::CfgDataW-1:0] cfg_data_i;

  grating_scoreboard sb;
  bit src_idle_en;
  bit sink_idle_en;
  int sink_hold;

  rotated_grating_pixel_generator_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: check each accepted beat, then decide the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_level(m_axis_tdata);
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 12);
    end
  end

  task automatic send_beat(bit is_query, bit signed [16:0] d_ang, bit signed [9:0] d_x,
                           bit signed [9:0] d_y, bit [4:0] px, bit [4:0] py);
    while (src_idle_en && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= is_query;
    s_axis_tdata  <= {1'b0, py, px, d_y, d_x, d_ang};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(is_query, d_ang, d_x, d_y, px, py);
  endtask

  task automatic send_random(int count);
    for (int n = 0; n < count; n++) begin
      send_beat($urandom_range(99) < 60, 17'($urandom_range(92160)) - 17'sd46080,
                10'($urandom_range(638)) - 10'sd319, 10'($urandom_range(638)) - 10'sd319,
                5'($urandom), 5'($urandom));
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Advances give no result, so the block may still be busy once the queue is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.level_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [2:0] idx, bit [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(bit gm, bit [7:0] per, bit [7:0] sw, bit [7:0] fg, bit [7:0] bg);
    write_reg(rgpg_pkg::CfgGrayMode, {7'd0, gm});
    write_reg(rgpg_pkg::CfgPeriod, per);
    write_reg(rgpg_pkg::CfgWidth, sw);
    write_reg(rgpg_pkg::CfgForeground, fg);
    write_reg(rgpg_pkg::CfgBackground, bg);
  endtask

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_state();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    sink_hold     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset settings, with no idling at all.
    send_beat(1'b1, 17'sd0, 10'sd0, 10'sd0, 5'd0, 5'd0);
    send_beat(1'b1, 17'sd0, 10'sd0, 10'sd0, 5'd31, 5'd31);
    send_beat(1'b0, 17'sd46080, 10'sd319, 10'sd319, 5'd31, 5'd31);
    send_beat(1'b1, -17'sd46080, -10'sd319, 10'sd319, 5'd0, 5'd31);
    send_beat(1'b0, 17'sd11520, -10'sd319, -10'sd319, 5'd0, 5'd0);
    send_beat(1'b1, 17'sd0, 10'sd0, 10'sd0, 5'd31, 5'd0);
    send_beat(1'b0, -17'sd46080, 10'sd319, 10'sd0, 5'd0, 5'd0);
    send_beat(1'b0, 17'sd46079, 10'sd319, 10'sd319, 5'd0, 5'd0);
    send_beat(1'b1, 17'sd0, 10'sd0, 10'sd0, 5'd16, 5'd16);
    send_beat(1'b0, -17'sd46079, -10'sd319, -10'sd319, 5'd0, 5'd0);
    send_beat(1'b0, -17'sd46079, -10'sd319, -10'sd1, 5'd0, 5'd0);
    send_beat(1'b1, -17'sd1, -10'sd1, -10'sd1, 5'd0, 5'd31);
    send_beat(1'b0, 17'sd129, 10'sd1, -10'sd1, 5'd31, 5'd31);
    send_beat(1'b1, 17'sd0, 10'sd0, 10'sd0, 5'd7, 5'd25);
    send_beat(1'b0, 17'sd23040, 10'sd0, 10'sd0, 5'd0, 5'd0);
    send_beat(1'b1, 17'sd0, 10'sd0, 10'sd0, 5'd31, 5'd31);
    drain();

    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_random(250);
    drain();

    // Binary stripes; the result side holds off while the sender keeps offering beats.
    set_config(1'b0, 8'd8, 8'd3, 8'd255, 8'd0);
    sink_hold = 400;
    send_random(250);
    drain();

    set_config(1'b1, 8'd1, 8'd0, 8'd0, 8'd255);
    send_random(120);
    drain();
    send_random(130);
    drain();

    set_config(1'b0, 8'd255, 8'd255, 8'd200, 8'd17);
    send_random(250);
    drain();

    set_config(1'b1, 8'd255, 8'd128, 8'd0, 8'd0);
    send_random(250);
    drain();

    // A zero period behaves as a period of one.
    set_config(1'b0, 8'd0, 8'd0, 8'd255, 8'd255);
    send_random(200);
    drain();

    set_config(1'b1, 8'd0, 8'd7, 8'd100, 8'd200);
    write_reg(3'd5, 8'd77);
    write_reg(3'd7, 8'd1);
    send_random(200);
    drain();

    // Long stretch without idling on either side.
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_config(1'b0, 8'd13, 8'd5, 8'd90, 8'd33);
    send_random(200);
    drain();

    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    set_config(1'b1, 8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom), 8'($urandom));
    send_random(200);
    drain();

    if (sb.level_q.size() != 0) begin
      $error("pixel_level: %0d expected results never arrived", sb.level_q.size());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
